### rtl/ncg_pkg.sv
// Shared types and constants for the next-combination generator.
// No dependencies; ncg_seq, the top, the checker and the bench import this package.
`timescale 1ns / 1ps

package ncg_pkg;

    // Fixed field widths
    localparam int SIZE_W     = 5;
    localparam int COUNT_W    = 8;
    localparam int INDEX_W    = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_SUBSET_SIZE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CANDIDATE_COUNT = 2'd1;

    // Status carried on every beat of one request
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DONE    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FIRST,
        SEQ_SCAN,
        SEQ_EMIT
    } seq_state_t;

    // Live configuration handed to the sequencer
    typedef struct packed {
        logic [SIZE_W-1:0]  subset_size;
        logic [COUNT_W-1:0] candidate_count;
    } ncg_cfg_t;

    // Side information of one result beat
    typedef struct packed {
        logic [INDEX_W-1:0] element_index;
        status_t            status;
        logic               last_element;
    } ncg_meta_t;

endpackage

### rtl/ncg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ncg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ncg_seq.sv
// Sequencer of the next-combination generator: scans the stored list,
// picks the element to bump and streams the new list. Uses ncg_pkg and ncg_ram.
`timescale 1ns / 1ps

module ncg_seq #(
    parameter int MAX_SUBSET  = 16,
    parameter int VALUE_WIDTH = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ncg_pkg::ncg_cfg_t      cfg,
    input  logic                   cfg_clear,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_restart,
    output logic                   beat_valid,
    input  logic                   beat_ready,
    output logic [VALUE_WIDTH-1:0] beat_value,
    output ncg_pkg::ncg_meta_t     beat_meta
);

    import ncg_pkg::*;

    localparam int AW  = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
    localparam int CW  = $clog2(MAX_SUBSET + 1);
    localparam int LW  = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
    localparam int UW  = ((VALUE_WIDTH + 1) > (COUNT_W + 1)) ? (VALUE_WIDTH + 1)
                                                             : (COUNT_W + 1);

    seq_state_t             state_reg,   state_next;
    logic                   cleared_reg, cleared_next;
    logic                   invalid_reg, invalid_next;
    status_t                status_reg,  status_next;
    logic [CW-1:0]          pos_reg,     pos_next;
    logic [CW-1:0]          split_reg,   split_next;
    logic [VALUE_WIDTH-1:0] newval_reg,  newval_next;
    logic [VALUE_WIDTH-1:0] cur_reg,     cur_next;

    logic [CW-1:0]          rd_cnt;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   ram_we;
    logic [VALUE_WIDTH-1:0] emit_value;

    logic [LW-1:0]          k_ext;
    logic [CW-1:0]          k_cnt;
    logic [CW-1:0]          pos_inc;
    logic                   pos_top;
    logic                   cfg_bad;
    logic [UW-1:0]          upper;
    logic [UW-1:0]          cur_plus;
    logic                   can_inc;
    logic                   is_last;
    logic                   beat_fire;

    // Store of the current combination
    ncg_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_SUBSET),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (emit_value),
        .raddr (rd_cnt[AW-1:0]),
        .rdata (rd_data)
    );

    // Configuration checks and scan compare
    always_comb begin
        k_ext    = LW'(cfg.subset_size);
        k_cnt    = CW'(cfg.subset_size);
        cfg_bad  = (cfg.subset_size == '0) || (cfg.candidate_count == '0) ||
                   (COUNT_W'(cfg.subset_size) > cfg.candidate_count) ||
                   (k_ext > LW'(MAX_SUBSET));
        pos_inc  = pos_reg + 1'b1;
        pos_top  = (LW'(pos_inc) >= k_ext);
        upper    = pos_top ? (UW'(cfg.candidate_count) + 1'b1) : UW'(rd_data);
        cur_plus = UW'(cur_reg) + 1'b1;
        can_inc  = (upper > cur_plus);
        is_last  = invalid_reg || (LW'(pos_inc) == k_ext);
    end

    // Beat contents: zero when invalid, else reloaded low part, bumped element, untouched high part
    always_comb begin
        if (invalid_reg) begin
            emit_value = '0;
        end else if (pos_reg < split_reg) begin
            emit_value = VALUE_WIDTH'(pos_inc);
        end else if (pos_reg == split_reg) begin
            emit_value = newval_reg;
        end else begin
            emit_value = rd_data;
        end
    end

    assign beat_valid              = (state_reg == SEQ_EMIT);
    assign beat_fire               = beat_valid && beat_ready;
    assign beat_value              = emit_value;
    assign beat_meta.element_index = INDEX_W'(pos_reg);
    assign beat_meta.status        = status_reg;
    assign beat_meta.last_element  = is_last;
    assign ram_we                  = beat_fire && !invalid_reg && (pos_reg <= split_reg);
    assign in_ready                = (state_reg == SEQ_IDLE);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            cleared_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            cleared_reg <= cleared_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        invalid_reg <= invalid_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        split_reg   <= split_next;
        newval_reg  <= newval_next;
        cur_reg     <= cur_next;
    end

    // Next state and read address
    always_comb begin
        state_next   = state_reg;
        cleared_next = cleared_reg;
        invalid_next = invalid_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        split_next   = split_reg;
        newval_next  = newval_reg;
        cur_next     = cur_reg;
        rd_cnt       = pos_reg;

        case (state_reg)
            SEQ_IDLE: begin
                rd_cnt   = '0;
                pos_next = '0;
                if (in_valid) begin
                    if (cfg_bad) begin
                        invalid_next = 1'b1;
                        status_next  = ST_INVALID;
                        state_next   = SEQ_EMIT;
                    end else if (in_restart || cleared_reg) begin
                        invalid_next = 1'b0;
                        status_next  = ST_OK;
                        split_next   = k_cnt;
                        cleared_next = 1'b0;
                        state_next   = SEQ_EMIT;
                    end else begin
                        invalid_next = 1'b0;
                        state_next   = SEQ_FIRST;
                    end
                end
            end
            SEQ_FIRST: begin
                // First element now on the read port; fetch the second
                rd_cnt   = CW'(1);
                pos_next = '0;
                if (rd_data == '0) begin
                    status_next = ST_OK;
                    split_next  = k_cnt;
                    state_next  = SEQ_EMIT;
                end else begin
                    cur_next   = rd_data;
                    state_next = SEQ_SCAN;
                end
            end
            SEQ_SCAN: begin
                if (can_inc) begin
                    // Bump this element, prime the read for the emit pass
                    status_next = ST_OK;
                    split_next  = pos_reg;
                    newval_next = VALUE_WIDTH'(cur_plus);
                    pos_next    = '0;
                    rd_cnt      = '0;
                    state_next  = SEQ_EMIT;
                end else if (pos_top) begin
                    // Wrapped round: reload the first combination
                    status_next = ST_DONE;
                    split_next  = k_cnt;
                    pos_next    = '0;
                    state_next  = SEQ_EMIT;
                end else begin
                    cur_next = rd_data;
                    pos_next = pos_inc;
                    rd_cnt   = pos_inc + 1'b1;
                end
            end
            SEQ_EMIT: begin
                if (beat_ready) begin
                    if (is_last) begin
                        state_next = SEQ_IDLE;
                    end else begin
                        pos_next = pos_inc;
                        rd_cnt   = pos_inc;
                    end
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase

        // A write to the subset-size or candidate-count register restarts the sequence
        if (cfg_clear) begin
            cleared_next = 1'b1;
        end
    end

endmodule

### rtl/next_combination_generator.sv
// Next-combination generator in colex order. Each beat on the slave side
// advances the stored k-of-n list (k = subset_size, n = candidate_count) and
// the block streams the new list on the master side, one beat per element,
// lowest first, tlast on the final one, with the status in tuser. A restart
// beat, the first beat after reset and the first beat after a write to either
// configuration register give 1..k; stepping past the last combination gives
// 1..k again with status finished; a bad configuration gives a single beat
// with status invalid and leaves the list alone. The list sits in a small RAM
// with one read and one write port, and the scan for the element to bump
// reads one entry per cycle, so a request is accepted, reads the first
// element, scans up to k entries and then emits k beats; a restart or first
// request skips the read and scan; a bad configuration emits its single beat.
// Reset needs no clearing pass, a flag marks the store as not started.
// Depends on ncg_pkg, ncg_seq and ncg_ram.
`timescale 1ns / 1ps

module next_combination_generator #(
    parameter int  MAX_SUBSET  = 16,
    parameter int  VALUE_WIDTH = 8,
    localparam int OUT_DATA_W  = ((VALUE_WIDTH + 4 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [ncg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ncg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ncg_pkg::IN_DATA_W-1:0]   s_tdata,   // [0] restart
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_DATA_W-1:0]           m_tdata,   // element_value, element_index
    output logic [1:0]                      m_tuser,   // status
    output logic                            m_tlast    // last_element
);

    import ncg_pkg::*;

    logic [SIZE_W-1:0]      subset_size_reg;
    logic [COUNT_W-1:0]     candidate_count_reg;
    ncg_cfg_t               cfg;
    logic                   cfg_clear;

    logic                   beat_valid;
    logic                   beat_ready;
    logic [VALUE_WIDTH-1:0] beat_value;
    ncg_meta_t              beat_meta;

    logic                   m_tvalid_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    logic [1:0]             m_tuser_reg;
    logic                   m_tlast_reg;

    // Configuration registers
    assign cfg_clear = cfg_we && ((cfg_addr == REG_SUBSET_SIZE) ||
                                  (cfg_addr == REG_CANDIDATE_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subset_size_reg     <= SIZE_W'(1);
            candidate_count_reg <= COUNT_W'(1);
        end else if (cfg_we) begin
            if (cfg_addr == REG_SUBSET_SIZE) begin
                subset_size_reg <= cfg_wdata[SIZE_W-1:0];
            end
            if (cfg_addr == REG_CANDIDATE_COUNT) begin
                candidate_count_reg <= cfg_wdata[COUNT_W-1:0];
            end
        end
    end

    assign cfg.subset_size     = subset_size_reg;
    assign cfg.candidate_count = candidate_count_reg;

    ncg_seq #(
        .MAX_SUBSET  (MAX_SUBSET),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cfg_clear  (cfg_clear),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_restart (s_tdata[0]),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat_value (beat_value),
        .beat_meta  (beat_meta)
    );

    // Output register: load when empty or being drained
    assign beat_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (beat_ready) begin
            m_tvalid_reg <= beat_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_ready && beat_valid) begin
            m_tdata_reg <= OUT_DATA_W'({beat_meta.element_index, beat_value});
            m_tuser_reg <= beat_meta.status;
            m_tlast_reg <= beat_meta.last_element;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/ncg_checker.sv
// Port-level checks for the next-combination generator, bound to the top.
// Depends on ncg_pkg and next_combination_generator.
`timescale 1ns / 1ps

module ncg_checker #(
    parameter int OUT_DATA_W = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser,
    input logic                  m_tlast
);

    import ncg_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Invalid configuration yields one zero beat that closes the request
    a_invalid_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_INVALID) |-> m_tlast && (m_tdata == '0))
        else $error("invalid-status beat is not a single zero beat");

    // One request at a time: no accept right after an accept
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while one is in progress");

    // Reset drops any pending result
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

endmodule

bind next_combination_generator ncg_checker #(
    .OUT_DATA_W (OUT_DATA_W)
) u_ncg_checker (.*);

### tb/tb_next_combination_generator.sv
// Self-checking bench for next_combination_generator: directed table, then random
// configuration phases, each result beat checked against a colex-order predictor
// or a typed-in beat. Depends on ncg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_next_combination_generator;
    import ncg_pkg::*;

    localparam int MAX_K        = 16;
    localparam int VAL_W        = 8;
    localparam int OUT_W        = ((VAL_W + 4 + 7) / 8) * 8;
    localparam int DIR_ROWS     = 37;
    localparam int RANDOM_ITEMS = 250;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 300;

    // Indexes beyond the register list, written to check that they are ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        logic                  restart;
        logic                  typed;
        logic [VAL_W-1:0]      exp_value;
        status_t               exp_status;
    } dir_row_t;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [INDEX_W-1:0] index;
        status_t            status;
        logic               last;
    } elem_beat_t;

    // One per request, in issue order: a typed-in beat replaces the prediction
    typedef struct packed {
        logic       typed;
        elem_beat_t beat;
    } req_tag_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    next_combination_generator #(
        .MAX_SUBSET  (MAX_K),
        .VALUE_WIDTH (VAL_W)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Predictor state: live configuration and the stored combination
    logic [SIZE_W-1:0]  pred_k = 5'd1;
    logic [COUNT_W-1:0] pred_n = 8'd1;
    logic [VAL_W-1:0]   combo_store [MAX_K];

    elem_beat_t expected_beats [$];
    req_tag_t   request_tags [$];

    int  mismatches    = 0;
    int  beats_checked = 0;
    int  requests_sent = 0;
    int  random_sent   = 0;
    int  cfg_writes    = 0;
    int  wraps_seen    = 0;
    int  invalid_seen  = 0;
    bit  idle_on       = 1'b1;
    int  rx_hold_left  = 0;
    int  rx_gap_left   = 0;

    dir_row_t directed_rows [DIR_ROWS];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("next_combination_generator: mismatch");
        $finish;
    end

    function automatic void clear_combo();
        foreach (combo_store[i]) combo_store[i] = '0;
    endfunction

    function automatic void load_first_combo(input int k);
        for (int i = 0; i < k; i++) combo_store[i] = VAL_W'(i + 1);
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    task automatic apply_register_write(input logic [CFG_ADDR_W-1:0] addr,
                                        input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_SUBSET_SIZE: begin
                pred_k = data[SIZE_W-1:0];
                clear_combo();
            end
            REG_CANDIDATE_COUNT: begin
                pred_n = data[COUNT_W-1:0];
                clear_combo();
            end
            default: ;
        endcase
    endtask

    // Advance the stored combination and queue the beats it produces, or the tag's typed-in beat
    task automatic predict_combination(input logic restart, input req_tag_t tag);
        int         k;
        int         n;
        int         upper;
        bit         bumped;
        status_t    st;
        elem_beat_t beat;
        elem_beat_t pred_q [$];
        k  = pred_k;
        n  = pred_n;
        st = ST_OK;
        if (k == 0 || n == 0 || k > n || k > MAX_K) begin
            beat = '{value: '0, index: '0, status: ST_INVALID, last: 1'b1};
            pred_q.push_back(beat);
            invalid_seen++;
        end else begin
            if (restart || combo_store[0] == '0) begin
                load_first_combo(k);
            end else begin
                bumped = 1'b0;
                // Bump the lowest element with room below its upper neighbour
                for (int i = 0; i < k && !bumped; i++) begin
                    upper = (i + 1 >= k) ? n + 1 : int'(combo_store[i + 1]);
                    if (upper > int'(combo_store[i]) + 1) begin
                        combo_store[i] = combo_store[i] + 1'b1;
                        for (int m = 0; m < i; m++) combo_store[m] = VAL_W'(m + 1);
                        bumped = 1'b1;
                    end
                end
                if (!bumped) begin
                    load_first_combo(k);
                    st = ST_DONE;
                    wraps_seen++;
                end
            end
            for (int i = 0; i < k; i++) begin
                beat = '{value: combo_store[i], index: INDEX_W'(i), status: st,
                         last: (i == k - 1)};
                pred_q.push_back(beat);
            end
        end
        if (tag.typed) expected_beats.push_back(tag.beat);
        else foreach (pred_q[i]) expected_beats.push_back(pred_q[i]);
    endtask

    // Track writes, accepted requests and result beats at each edge
    req_tag_t   cur_tag;
    elem_beat_t cur_exp;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) apply_register_write(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready) begin
                cur_tag = (request_tags.size() != 0) ? request_tags.pop_front() : '0;
                predict_combination(s_tdata[0], cur_tag);
            end
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat: value %0d index %0d status %0d last %0b",
                                            m_tdata[7:0], m_tdata[11:8], m_tuser, m_tlast));
                end else begin
                    cur_exp = expected_beats.pop_front();
                    beats_checked++;
                    if (m_tdata[VAL_W-1:0] !== cur_exp.value
                            || m_tdata[VAL_W+INDEX_W-1:VAL_W] !== cur_exp.index
                            || m_tuser !== cur_exp.status || m_tlast !== cur_exp.last) begin
                        note_mismatch($sformatf({"wrong beat: expected value %0d index %0d ",
                                                 "status %0d last %0b, got %0d %0d %0d %0b"},
                                                cur_exp.value, cur_exp.index, cur_exp.status,
                                                cur_exp.last, m_tdata[VAL_W-1:0],
                                                m_tdata[VAL_W+INDEX_W-1:VAL_W], m_tuser,
                                                m_tlast));
                    end
                end
            end
        end
    end

    // Receiver: long hold on request, random stall bursts otherwise
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else if (rx_gap_left > 0) begin
                m_tready <= 1'b0;
                rx_gap_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                rx_gap_left = $urandom_range(1, 8) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request beat, with an optional gap in front of it
    task automatic send_request(input logic restart, input req_tag_t tag);
        request_tags.push_back(tag);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tdata  <= IN_DATA_W'(restart);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Drop valid and hold until every expected beat has arrived
    task automatic wait_drained();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (expected_beats.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_addr  <= addr;
        cfg_wdata <= data;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        cfg_writes++;
    endtask

    initial begin
        int        phase;
        int        items;
        int        sel;
        int        kv;
        int        nv;
        bit        pressure;
        bit        saved_idle;
        req_tag_t  tag;

        clear_combo();
        directed_rows = '{
            // reset state k=1 n=1: first, wrapped, restarted
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd1, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd1, ST_DONE},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b1, 1'b1, 8'd1, ST_OK},
            // zero subset
            '{ROW_CFG, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd0, ST_INVALID},
            // zero candidates
            '{ROW_CFG, REG_SUBSET_SIZE,     8'd1,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_CFG, REG_CANDIDATE_COUNT, 8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd0, ST_INVALID},
            // subset larger than the set
            '{ROW_CFG, REG_CANDIDATE_COUNT, 8'd3,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_CFG, REG_SUBSET_SIZE,     8'd4,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd0, ST_INVALID},
            // subset beyond the store depth (upper bits masked off)
            '{ROW_CFG, REG_CANDIDATE_COUNT, 8'd255, 1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_CFG, REG_SUBSET_SIZE,     8'hF1,  1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd0, ST_INVALID},
            // 3 of 5: walk, then restart
            '{ROW_CFG, REG_SUBSET_SIZE,     8'd3,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_CFG, REG_CANDIDATE_COUNT, 8'd5,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b1, 1'b0, 8'd0, ST_OK},
            // writes to unused indexes keep the list
            '{ROW_CFG, REG_SPARE_A,         8'hFF,  1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_CFG, REG_SPARE_B,         8'h00,  1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            // full store, single combination: first load, then a wrap
            '{ROW_CFG, REG_SUBSET_SIZE,     8'd16,  1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_CFG, REG_CANDIDATE_COUNT, 8'd16,  1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            // full store, largest set
            '{ROW_CFG, REG_CANDIDATE_COUNT, 8'd255, 1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            // single element from the largest set
            '{ROW_CFG, REG_SUBSET_SIZE,     8'd1,   1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd1, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b0, 8'd0, ST_OK},
            // all write-data bits set: subset 31
            '{ROW_CFG, REG_SUBSET_SIZE,     8'hFF,  1'b0, 1'b0, 8'd0, ST_OK},
            '{ROW_REQ, REG_SUBSET_SIZE,     8'd0,   1'b0, 1'b1, 8'd0, ST_INVALID}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                cfg_write(directed_rows[r].addr, directed_rows[r].data);
            end else begin
                tag.typed = directed_rows[r].typed;
                tag.beat  = '{value: directed_rows[r].exp_value, index: '0,
                              status: directed_rows[r].exp_status, last: 1'b1};
                send_request(directed_rows[r].restart, tag);
            end
        end

        // Random phases: new configuration, then a run of requests
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                case ($urandom_range(0, 3))
                    0: begin kv = 0; nv = $urandom_range(1, 255); end
                    1: begin kv = $urandom_range(1, 16); nv = 0; end
                    2: begin nv = $urandom_range(1, 15); kv = $urandom_range(nv + 1, 16); end
                    default: begin kv = $urandom_range(17, 31); nv = $urandom_range(17, 255); end
                endcase
                items = $urandom_range(2, 5);
            end else if (sel == 1) begin
                kv = 16;
                nv = $urandom_range(16, 19);
                items = $urandom_range(3, 6);
            end else if (sel == 2) begin
                kv = $urandom_range(1, 4);
                nv = $urandom_range(100, 255);
                items = $urandom_range(10, 20);
            end else begin
                nv = $urandom_range(1, 7);
                kv = $urandom_range(1, nv);
                items = $urandom_range(15, 40);
            end

            if (random_sent >= RANDOM_ITEMS - 40) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 4) != 0);

            if ($urandom_range(0, 1)) begin
                cfg_write(REG_SUBSET_SIZE, {3'($urandom_range(0, 7)), 5'(kv)});
                cfg_write(REG_CANDIDATE_COUNT, 8'(nv));
            end else begin
                cfg_write(REG_CANDIDATE_COUNT, 8'(nv));
                cfg_write(REG_SUBSET_SIZE, {3'($urandom_range(0, 7)), 5'(kv)});
            end
            if ($urandom_range(0, 5) == 0)
                cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          8'($urandom_range(0, 255)));

            // Once: hold the receiver off while requests keep coming
            pressure = (phase == 2);
            saved_idle = idle_on;
            if (pressure) begin
                idle_on = 1'b0;
                items = 12;
                rx_hold_left = HOLD_CYCLES;
            end
            for (int j = 0; j < items; j++) begin
                send_request($urandom_range(0, 9) == 0, '0);
                random_sent++;
            end
            if (pressure) begin
                wait_drained();
                idle_on = saved_idle;
            end
            phase++;
        end

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("covered %0d requests in %0d random phases, %0d register writes",
                 requests_sent, phase, cfg_writes);
        $display("checked %0d beats, %0d wraparounds, %0d invalid-configuration replies",
                 beats_checked, wraps_seen, invalid_seen);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("next_combination_generator: match");
        end else begin
            $display("next_combination_generator: mismatch");
        end
        $finish;
    end

endmodule

### files.f
rtl/ncg_pkg.sv
rtl/ncg_ram.sv
rtl/ncg_seq.sv
rtl/next_combination_generator.sv
rtl/ncg_checker.sv
tb/tb_next_combination_generator.sv
